// File: hdl/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg
// Shared constants, types and the arctangent table for the phase remapper.
// ----------------------------------------------------------------------------
`default_nettype none

package spr_pkg;

  // guard bits below the sample lsb inside the cordic datapaths
  localparam int GUARD_BITS = 6;
  // depth of the arctangent table, and so the stage limit
  localparam int ATAN_ENTRIES = 30;
  localparam int INDEX_WIDTH = 13;
  localparam int ANGLE_WIDTH = 32;
  localparam int CFG_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 2;

  // 1/K^2 in Q30, K being the cordic gain
  localparam int INV_GAIN_WIDTH = 29;
  localparam int INV_GAIN_FRAC = 30;
  localparam logic [INV_GAIN_WIDTH-1:0] INV_GAIN_SQ = 29'd395948876;

  localparam logic [ANGLE_WIDTH-1:0] HALF_TURN = 32'h8000_0000;

  // defaults for the top level parameters
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int CORDIC_STAGES_DEF = 20;

  // register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PHASE_BIAS = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PHASE_SLOPE = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PHASE_PER_BIN = 2'd2;

  // reset values
  localparam logic [CFG_WIDTH-1:0] PHASE_BIAS_RST = 16'd0;
  localparam logic [CFG_WIDTH-1:0] PHASE_SLOPE_RST = 16'd4096;
  localparam logic [CFG_WIDTH-1:0] PHASE_PER_BIN_RST = 16'd0;

  // phase remap settings
  typedef struct packed {
    logic signed [CFG_WIDTH-1:0] bias;
    logic signed [CFG_WIDTH-1:0] slope;
    logic signed [CFG_WIDTH-1:0] per_bin;
  } phase_cfg_t;

  // atan(2^-i) as binary angles, one turn = 2^32
  function automatic logic [ANGLE_WIDTH-1:0] atan_angle(input logic [4:0] i);
    logic [ANGLE_WIDTH-1:0] a;
    unique case (i)
      5'd0:  a = 32'h2000_0000;
      5'd1:  a = 32'h12E4_051E;
      5'd2:  a = 32'h09FB_385B;
      5'd3:  a = 32'h0511_11D4;
      5'd4:  a = 32'h028B_0D43;
      5'd5:  a = 32'h0145_D7E1;
      5'd6:  a = 32'h00A2_F61E;
      5'd7:  a = 32'h0051_7C55;
      5'd8:  a = 32'h0028_BE53;
      5'd9:  a = 32'h0014_5F2F;
      5'd10: a = 32'h000A_2F98;
      5'd11: a = 32'h0005_17CC;
      5'd12: a = 32'h0002_8BE6;
      5'd13: a = 32'h0001_45F3;
      5'd14: a = 32'h0000_A2FA;
      5'd15: a = 32'h0000_517D;
      5'd16: a = 32'h0000_28BE;
      5'd17: a = 32'h0000_145F;
      5'd18: a = 32'h0000_0A30;
      5'd19: a = 32'h0000_0518;
      5'd20: a = 32'h0000_028C;
      5'd21: a = 32'h0000_0146;
      5'd22: a = 32'h0000_00A3;
      5'd23: a = 32'h0000_0051;
      5'd24: a = 32'h0000_0029;
      5'd25: a = 32'h0000_0014;
      5'd26: a = 32'h0000_000A;
      5'd27: a = 32'h0000_0005;
      5'd28: a = 32'h0000_0003;
      5'd29: a = 32'h0000_0001;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// File: hdl/spr_vector.sv
// ----------------------------------------------------------------------------
// spr_vector
// Cordic vectoring pipeline: magnitude (with gain) and phase of one bin.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_vector
  import spr_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int NUM_STAGES = CORDIC_STAGES_DEF,
  parameter int XW = SAMPLE_WIDTH + GUARD_BITS + 3
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic                           in_valid,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_re,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_im,
  input  wire logic [INDEX_WIDTH-1:0]         in_idx,
  output logic                                out_valid,
  output logic signed [XW-1:0]                out_x,
  output logic [ANGLE_WIDTH-1:0]              out_z,
  output logic [INDEX_WIDTH-1:0]              out_idx
);

  logic                    v_r   [NUM_STAGES+1];
  logic signed [XW-1:0]    x_r   [NUM_STAGES+1];
  logic signed [XW-1:0]    y_r   [NUM_STAGES+1];
  logic [ANGLE_WIDTH-1:0]  z_r   [NUM_STAGES+1];
  logic [INDEX_WIDTH-1:0]  idx_r [NUM_STAGES+1];

  logic signed [XW-1:0] x_in, y_in;

  // scale up by the guard bits
  assign x_in = XW'(in_re) <<< GUARD_BITS;
  assign y_in = XW'(in_im) <<< GUARD_BITS;

  // pre-rotation into the right half plane
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
    if (en) begin
      idx_r[0] <= in_idx;
      if (x_in < 0) begin
        x_r[0] <= -x_in;
        y_r[0] <= -y_in;
        z_r[0] <= HALF_TURN;
      end else begin
        x_r[0] <= x_in;
        y_r[0] <= y_in;
        z_r[0] <= '0;
      end
    end
  end

  // micro-rotations, one per stage, driving y to zero
  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
    logic signed [XW-1:0] dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
      if (en) begin
        idx_r[i+1] <= idx_r[i];
        if (y_r[i] < 0) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - atan_angle(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + atan_angle(5'(i));
        end
      end
    end
  end

  assign out_valid = v_r[NUM_STAGES];
  assign out_x     = x_r[NUM_STAGES];
  assign out_z     = z_r[NUM_STAGES];
  assign out_idx   = idx_r[NUM_STAGES];

endmodule

`default_nettype wire

// File: hdl/spr_phase.sv
// ----------------------------------------------------------------------------
// spr_phase
// Gain correction of the magnitude and new phase, two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_phase
  import spr_pkg::*;
#(
  parameter int XW = SAMPLE_WIDTH_DEF + GUARD_BITS + 3
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire phase_cfg_t             cfg,
  input  wire logic                   in_valid,
  input  wire logic signed [XW-1:0]   in_x,
  input  wire logic [ANGLE_WIDTH-1:0] in_z,
  input  wire logic [INDEX_WIDTH-1:0] in_idx,
  output logic                        out_valid,
  output logic signed [XW-1:0]        out_mag,
  output logic [ANGLE_WIDTH-1:0]      out_angle
);

  localparam int MW = XW - 1;
  localparam int PW = MW + INV_GAIN_WIDTH;
  localparam int SPW = CFG_WIDTH + ANGLE_WIDTH;
  localparam int SLOPE_FRAC = 12;

  logic                  va_r, vb_r;
  logic [PW-1:0]         prod_r;
  logic signed [SPW-1:0] slope_prod_r;
  logic [CFG_WIDTH-1:0]  upper_r;
  logic signed [XW-1:0]  mag_r;
  logic [ANGLE_WIDTH-1:0] angle_r;

  logic signed [SPW-1:0] slope_sum;

  // stage a: products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
    if (en) begin
      prod_r       <= PW'(MW'(in_x)) * PW'(INV_GAIN_SQ);
      slope_prod_r <= SPW'(cfg.slope) * SPW'($signed(in_z));
      upper_r      <= CFG_WIDTH'(cfg.bias) + CFG_WIDTH'(cfg.per_bin * CFG_WIDTH'(in_idx));
    end
  end

  // rounding of the slope term, then the sum modulo one turn
  assign slope_sum = slope_prod_r + SPW'(2048);

  // stage b: magnitude and angle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
    if (en) begin
      mag_r   <= XW'(prod_r >> INV_GAIN_FRAC);
      angle_r <= {upper_r, 16'd0} + slope_sum[SLOPE_FRAC +: ANGLE_WIDTH];
    end
  end

  assign out_valid = vb_r;
  assign out_mag   = mag_r;
  assign out_angle = angle_r;

endmodule

`default_nettype wire

// File: hdl/spr_rotate.sv
// ----------------------------------------------------------------------------
// spr_rotate
// Cordic rotation pipeline with rounding and saturation to the sample range.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_rotate
  import spr_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int NUM_STAGES = CORDIC_STAGES_DEF,
  parameter int XW = SAMPLE_WIDTH + GUARD_BITS + 3
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic signed [XW-1:0]    in_mag,
  input  wire logic [ANGLE_WIDTH-1:0]  in_angle,
  output logic                         out_valid,
  output logic signed [SAMPLE_WIDTH-1:0] out_re,
  output logic signed [SAMPLE_WIDTH-1:0] out_im,
  output logic                         out_clip
);

  localparam logic signed [XW-1:0] S_MAX = XW'((64'sd1 <<< (SAMPLE_WIDTH-1)) - 1);
  localparam logic signed [XW-1:0] S_MIN = -S_MAX - XW'(1);

  logic                           v_r [NUM_STAGES+1];
  logic signed [XW-1:0]           x_r [NUM_STAGES+1];
  logic signed [XW-1:0]           y_r [NUM_STAGES+1];
  logic signed [ANGLE_WIDTH-1:0]  r_r [NUM_STAGES+1];

  logic                           vo_r, clip_r;
  logic signed [SAMPLE_WIDTH-1:0] re_r, im_r;

  logic [1:0] quad;
  assign quad = in_angle[ANGLE_WIDTH-1 -: 2];

  // pre-rotation into the right half plane
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
    if (en) begin
      y_r[0] <= '0;
      if (quad == 2'd1 || quad == 2'd2) begin
        x_r[0] <= -in_mag;
        r_r[0] <= $signed(in_angle ^ HALF_TURN);
      end else begin
        x_r[0] <= in_mag;
        r_r[0] <= $signed(in_angle);
      end
    end
  end

  // micro-rotations, driving the residual angle to zero
  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
    logic signed [XW-1:0] dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
      if (en) begin
        if (r_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          r_r[i+1] <= r_r[i] - $signed(atan_angle(5'(i)));
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          r_r[i+1] <= r_r[i] + $signed(atan_angle(5'(i)));
        end
      end
    end
  end

  // round off the guard bits and saturate
  logic signed [XW-1:0] rx, ry;
  logic                 cx_hi, cx_lo, cy_hi, cy_lo;
  assign rx    = (x_r[NUM_STAGES] + XW'(32)) >>> GUARD_BITS;
  assign ry    = (y_r[NUM_STAGES] + XW'(32)) >>> GUARD_BITS;
  assign cx_hi = rx > S_MAX;
  assign cx_lo = rx < S_MIN;
  assign cy_hi = ry > S_MAX;
  assign cy_lo = ry < S_MIN;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_r[NUM_STAGES];
    end
    if (en) begin
      re_r   <= cx_hi ? SAMPLE_WIDTH'(S_MAX) : (cx_lo ? SAMPLE_WIDTH'(S_MIN)
                                                      : SAMPLE_WIDTH'(rx));
      im_r   <= cy_hi ? SAMPLE_WIDTH'(S_MAX) : (cy_lo ? SAMPLE_WIDTH'(S_MIN)
                                                      : SAMPLE_WIDTH'(ry));
      clip_r <= cx_hi | cx_lo | cy_hi | cy_lo;
    end
  end

  assign out_valid = vo_r;
  assign out_re    = re_r;
  assign out_im    = im_r;
  assign out_clip  = clip_r;

endmodule

`default_nettype wire

// File: hdl/spectral_phase_remap.sv
// ----------------------------------------------------------------------------
// spectral_phase_remap
// Keeps the magnitude of a spectrum bin and replaces its phase with
// bias + slope * phase + per_bin * index, via cordic vectoring and rotation.
// ----------------------------------------------------------------------------
// channel   direction  signals
// in_       input      in_valid, in_ready, in_bin_real, in_bin_imag, in_bin_index
// out_      output     out_valid, out_ready, out_real, out_imag, out_clipped
// cfg_      input      cfg_we, cfg_index, cfg_data
//
// one bin per cycle while the output is not stalled; the path is the vectoring pipeline,
// gain and phase stages, the rotation pipeline and an output register, stages = min(CORDIC_STAGES, 30)
// synchronous active-low reset clears the valid bits and the configuration registers
// a stall on the output freezes the whole pipeline; in_ready follows it
// ----------------------------------------------------------------------------
`default_nettype none

module spectral_phase_remap
  import spr_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  wire logic [CFG_WIDTH-1:0]           cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_bin_real,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_bin_imag,
  input  wire logic [INDEX_WIDTH-1:0]         in_bin_index,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]      out_real,
  output logic signed [SAMPLE_WIDTH-1:0]      out_imag,
  output logic                                out_clipped
);

  localparam int NS = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int XW = SAMPLE_WIDTH + GUARD_BITS + 3;

  phase_cfg_t cfg_r;
  logic       en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bias    <= PHASE_BIAS_RST;
      cfg_r.slope   <= PHASE_SLOPE_RST;
      cfg_r.per_bin <= PHASE_PER_BIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PHASE_BIAS:    cfg_r.bias    <= cfg_data;
        REG_PHASE_SLOPE:   cfg_r.slope   <= cfg_data;
        REG_PHASE_PER_BIN: cfg_r.per_bin <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advances unless a finished result waits
  assign en       = out_ready | ~out_valid;
  assign in_ready = en;

  logic                   vec_valid;
  logic signed [XW-1:0]   vec_x;
  logic [ANGLE_WIDTH-1:0] vec_z;
  logic [INDEX_WIDTH-1:0] vec_idx;
  logic                   ph_valid;
  logic signed [XW-1:0]   ph_mag;
  logic [ANGLE_WIDTH-1:0] ph_angle;

  spr_vector #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .NUM_STAGES   (NS),
    .XW           (XW)
  ) u_vector (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_re     (in_bin_real),
    .in_im     (in_bin_imag),
    .in_idx    (in_bin_index),
    .out_valid (vec_valid),
    .out_x     (vec_x),
    .out_z     (vec_z),
    .out_idx   (vec_idx)
  );

  spr_phase #(
    .XW (XW)
  ) u_phase (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .cfg       (cfg_r),
    .in_valid  (vec_valid),
    .in_x      (vec_x),
    .in_z      (vec_z),
    .in_idx    (vec_idx),
    .out_valid (ph_valid),
    .out_mag   (ph_mag),
    .out_angle (ph_angle)
  );

  spr_rotate #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .NUM_STAGES   (NS),
    .XW           (XW)
  ) u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (ph_valid),
    .in_mag    (ph_mag),
    .in_angle  (ph_angle),
    .out_valid (out_valid),
    .out_re    (out_real),
    .out_im    (out_imag),
    .out_clip  (out_clipped)
  );

endmodule

`default_nettype wire
